// ===== hdl/spg_pkg.sv =====
// Shared types and constants for the Sobol point generator.
// Holds the primitive polynomial table and the direction word function.
// No dependencies.
package spg_pkg;

    // Direction words per dimension and polynomial rows in the table
    localparam int unsigned DIR_BITS  = 32;
    localparam int unsigned POLY_ROWS = 39;
    localparam int unsigned INIT_MAX  = 8;

    // Configuration register indexes
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_SEED_OFFSET = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DIMS_IN_USE = 1'b1;

    localparam int unsigned CFG_DATA_W = 64;
    localparam logic [5:0]  DIMS_RESET = 6'd40;

    // Request and result payloads
    typedef struct packed {
        logic [63:0] point_index;
        logic [5:0]  dimension;
    } point_t;

    typedef struct packed {
        logic [31:0] coordinate;
        logic        dim_error;
    } sample_t;

    // Primitive polynomial rows: degree, inner coefficients, initial m values
    localparam int unsigned POLY_DEG [POLY_ROWS] = '{
        1, 2, 3, 3, 4, 4, 5, 5, 5, 5, 5, 5, 6, 6, 6, 6, 6, 6,
        7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7,
        8, 8, 8
    };

    localparam int unsigned POLY_COEF [POLY_ROWS] = '{
        0, 1, 1, 2, 1, 4, 2, 4, 7, 11, 13, 14, 1, 13, 16, 19, 22, 25,
        1, 4, 7, 8, 14, 19, 21, 28, 31, 32, 37, 41, 42, 50, 55, 56, 59, 62,
        14, 21, 22
    };

    localparam logic [7:0] POLY_INIT [POLY_ROWS][INIT_MAX] = '{
        '{8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd3, 8'd3, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd5, 8'd13, 8'd0, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd5, 8'd5, 8'd17, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd5, 8'd5, 8'd5, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd7, 8'd11, 8'd19, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd5, 8'd1, 8'd1, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd1, 8'd3, 8'd11, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd5, 8'd5, 8'd31, 8'd0, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd3, 8'd9, 8'd7, 8'd49, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd1, 8'd15, 8'd21, 8'd21, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd13, 8'd27, 8'd49, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd1, 8'd15, 8'd7, 8'd5, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd15, 8'd13, 8'd25, 8'd0, 8'd0},
        '{8'd1, 8'd1, 8'd5, 8'd5, 8'd19, 8'd61, 8'd0, 8'd0},
        '{8'd1, 8'd3, 8'd7, 8'd11, 8'd23, 8'd15, 8'd103, 8'd0},
        '{8'd1, 8'd3, 8'd7, 8'd13, 8'd13, 8'd15, 8'd69, 8'd0},
        '{8'd1, 8'd1, 8'd3, 8'd13, 8'd7, 8'd35, 8'd63, 8'd0},
        '{8'd1, 8'd3, 8'd5, 8'd9, 8'd1, 8'd25, 8'd53, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd13, 8'd9, 8'd35, 8'd107, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd5, 8'd27, 8'd61, 8'd31, 8'd0},
        '{8'd1, 8'd1, 8'd5, 8'd11, 8'd19, 8'd41, 8'd61, 8'd0},
        '{8'd1, 8'd3, 8'd5, 8'd3, 8'd3, 8'd13, 8'd69, 8'd0},
        '{8'd1, 8'd1, 8'd7, 8'd13, 8'd1, 8'd19, 8'd1, 8'd0},
        '{8'd1, 8'd3, 8'd7, 8'd5, 8'd13, 8'd19, 8'd59, 8'd0},
        '{8'd1, 8'd1, 8'd3, 8'd9, 8'd25, 8'd29, 8'd41, 8'd0},
        '{8'd1, 8'd3, 8'd5, 8'd13, 8'd23, 8'd1, 8'd55, 8'd0},
        '{8'd1, 8'd3, 8'd7, 8'd3, 8'd13, 8'd59, 8'd17, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd3, 8'd5, 8'd53, 8'd69, 8'd0},
        '{8'd1, 8'd1, 8'd5, 8'd5, 8'd23, 8'd33, 8'd13, 8'd0},
        '{8'd1, 8'd1, 8'd7, 8'd7, 8'd1, 8'd61, 8'd123, 8'd0},
        '{8'd1, 8'd1, 8'd7, 8'd9, 8'd13, 8'd61, 8'd49, 8'd0},
        '{8'd1, 8'd3, 8'd3, 8'd5, 8'd3, 8'd55, 8'd33, 8'd0},
        '{8'd1, 8'd3, 8'd1, 8'd15, 8'd31, 8'd13, 8'd49, 8'd245},
        '{8'd1, 8'd3, 8'd5, 8'd15, 8'd31, 8'd59, 8'd63, 8'd97},
        '{8'd1, 8'd3, 8'd1, 8'd11, 8'd11, 8'd11, 8'd77, 8'd249}
    };

    // Direction word j of dimension d; called with constant arguments only,
    // so the recurrence is evaluated at elaboration.
    function automatic logic [31:0] dir_word(int unsigned d, int unsigned j);
        logic [31:0] w [DIR_BITS];
        logic [31:0] v;
        int unsigned r;
        int unsigned s;
        int unsigned a;
        // Dimension zero, and any dimension beyond the table, is van der Corput
        if (d == 0 || d > POLY_ROWS) begin
            return 32'h8000_0000 >> j;
        end
        r = d - 1;
        s = POLY_DEG[r];
        a = POLY_COEF[r];
        for (int i = 0; i < DIR_BITS; i++) begin
            w[i] = '0;
        end
        for (int unsigned i = 0; i < s; i++) begin
            w[i] = 32'(POLY_INIT[r][i]) << (31 - i);
        end
        for (int unsigned i = s; i < DIR_BITS; i++) begin
            v = w[i-s] ^ (w[i-s] >> s);
            for (int unsigned k = 1; k < s; k++) begin
                if (((a >> (s - 1 - k)) & 1) != 0) begin
                    v = v ^ w[i-k];
                end
            end
            w[i] = v;
        end
        return w[j];
    endfunction

endpackage

// ===== hdl/sobol_point_generator.sv =====
// Top level of the Sobol point generator: three-stage pipeline.
// Depends on spg_pkg for payload types, register indexes and direction words.

// One Sobol coordinate per request, Q0.32, with a new request taken every
// clock cycle: busy stays low, so a request transfers whenever start is high.
// The result appears on sample with done high once its request has passed
// the input register, Gray code register and result register, and is valid
// for a single cycle; the receiver cannot hold it off. Requests for a
// dimension at or above dims_in_use or MAX_DIMS return a zero coordinate with
// dim_error set. Direction words are constants built at elaboration.
// Write seed_offset and dims_in_use only while no request is in flight.
module sobol_point_generator #(
    parameter int unsigned MAX_DIMS = 40
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  spg_pkg::point_t                   point,
    output logic                              done,
    output spg_pkg::sample_t                  sample,
    input  logic                              wr_en,
    input  logic [spg_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [spg_pkg::CFG_DATA_W-1:0]    wr_data
);

    localparam int unsigned DIM_IDX_W = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int unsigned NBITS     = spg_pkg::DIR_BITS;

    // Configuration: seed is stored plus one so only one add remains
    logic [63:0] seed_inc_reg;
    logic [5:0]  dims_in_use_reg;

    // Pipeline registers
    logic                   s1_valid_reg;
    spg_pkg::point_t        s1_point_reg;
    logic                   s2_valid_reg;
    logic [NBITS-1:0]       s2_gray_reg;
    logic [DIM_IDX_W-1:0]   s2_dim_reg;
    logic                   s2_err_reg;
    logic                   done_reg;
    spg_pkg::sample_t       sample_reg;

    logic [NBITS:0]         pos_next;
    logic [NBITS-1:0]       gray_next;
    logic                   err_next;
    logic [NBITS-1:0]       coord_next;

    logic [NBITS-1:0]       dir_rows [MAX_DIMS][NBITS];
    logic [NBITS-1:0]       sel_row  [NBITS];

    // Constant direction word table
    for (genvar d = 0; d < MAX_DIMS; d++) begin : g_dim
        for (genvar j = 0; j < NBITS; j++) begin : g_word
            localparam logic [31:0] WORD = spg_pkg::dir_word(d, j);
            assign dir_rows[d][j] = WORD;
        end
    end

    assign busy = 1'b0;

    // Register writes
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            seed_inc_reg    <= 64'd1;
            dims_in_use_reg <= spg_pkg::DIMS_RESET;
        end
        else if (wr_en) begin
            case (wr_index)
                spg_pkg::REG_SEED_OFFSET: seed_inc_reg    <= wr_data[63:0] + 64'd1;
                spg_pkg::REG_DIMS_IN_USE: dims_in_use_reg <= wr_data[5:0];
                default: ;
            endcase
        end
    end

    // Position and Gray code: only the low 33 bits of the position matter
    always_comb
    begin
        pos_next  = s1_point_reg.point_index[NBITS:0] + seed_inc_reg[NBITS:0];
        gray_next = pos_next[NBITS-1:0] ^ pos_next[NBITS:1];
        err_next  = (s1_point_reg.dimension >= dims_in_use_reg) ||
                    (s1_point_reg.dimension >= 6'(MAX_DIMS));
    end

    // Select the dimension's words and fold in those the Gray code picks; flagged requests give zero
    always_comb
    begin
        sel_row    = dir_rows[s2_dim_reg];
        coord_next = '0;
        for (int j = 0; j < NBITS; j++) begin
            coord_next = coord_next ^ (sel_row[j] & {NBITS{s2_gray_reg[j]}});
        end
        if (s2_err_reg) begin
            coord_next = '0;
        end
    end

    // Advance valid flags
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else begin
            s1_valid_reg <= start;
            s2_valid_reg <= s1_valid_reg;
            done_reg     <= s2_valid_reg;
        end
    end

    // Hold payload of each stage
    always_ff @(posedge clk) begin
        if (start) begin
            s1_point_reg <= point;
        end
        if (s1_valid_reg) begin
            s2_gray_reg <= gray_next;
            s2_dim_reg  <= s1_point_reg.dimension[DIM_IDX_W-1:0];
            s2_err_reg  <= err_next;
        end
        if (s2_valid_reg) begin
            sample_reg.coordinate <= coord_next;
            sample_reg.dim_error  <= s2_err_reg;
        end
    end

    assign done   = done_reg;
    assign sample = sample_reg;

endmodule

// ===== hdl/spg_checker.sv =====
// Port-level checker for the Sobol point generator, bound to the top level.
// Depends on spg_pkg for payload types.
module spg_checker #(
    parameter int unsigned MAX_DIMS = 40
) (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input spg_pkg::point_t     point,
    input logic                done,
    input spg_pkg::sample_t    sample
);

    // Every request transfer yields a matching result on done
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##3 done)
        else $error("transfer without result three cycles later");

    // No result without a matching earlier request transfer
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 3))
        else $error("result without a matching request");

    // Flagged results carry a zero coordinate
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && sample.dim_error) |-> (sample.coordinate == 32'd0))
        else $error("flagged result with nonzero coordinate");

    // Dimensions beyond the build limit are always flagged
    a_max_dims: assert property (@(posedge clk) disable iff (!rst_n)
        (done && $past(point.dimension >= 6'(MAX_DIMS), 3)) |-> sample.dim_error)
        else $error("dimension beyond limit not flagged");

endmodule

bind sobol_point_generator spg_checker #(
    .MAX_DIMS (MAX_DIMS)
) u_spg_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .point  (point),
    .done   (done),
    .sample (sample)
);
